// ----- hdl/delayed_spike_synapse_table_macros.svh -----
// Assertion macros shared by the synapse table RTL.
// Every macro expects clk and rst_n in scope.
`ifndef DELAYED_SPIKE_SYNAPSE_TABLE_MACROS_SVH
`define DELAYED_SPIKE_SYNAPSE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define DSST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("synapse table check failed");

// Next-cycle implication
`define DSST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("synapse table check failed");

`else

`define DSST_ASSERT_NOW(label, ante, cons)
`define DSST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hdl/dsst_pkg.sv -----
package dsst_pkg;

    // Table geometry
    localparam int SYNAPSES = 256;
    localparam int IDX_W    = 8;
    localparam int RING_W   = 5;
    localparam int RING_LEN = 1 << RING_W;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int WEIGHT_W = 24;
    localparam int DECAY_W  = 16;
    localparam int DELAY_W  = 5;
    localparam int RESP_W   = 32;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPIKE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [IDX_W-1:0]           synapse_index;
        logic signed [WEIGHT_W-1:0] weight;
        logic [DECAY_W-1:0]         decay;
        logic [DELAY_W-1:0]         delay_ticks;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         synapse_echo;
        logic signed [RESP_W-1:0] response;
        logic                     spike_delivered;
        logic                     collision_error;
    } out_item_t;

    // One synapse's full state, stored as one memory word
    typedef struct packed {
        logic [RING_LEN-1:0]        ring;
        logic [RING_W-1:0]          read_pos;
        logic [DELAY_W-1:0]         delay;
        logic signed [WEIGHT_W-1:0] weight;
        logic [DECAY_W-1:0]         decay;
        logic signed [RESP_W-1:0]   response;
    } entry_t;

    // Write-back request into the table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           entry;
    } wr_req_t;

endpackage

// ----- hdl/dsst_entry_ram.sv -----
module dsst_entry_ram (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [dsst_pkg::IDX_W-1:0] rd_addr,
    output dsst_pkg::entry_t      rd_entry,
    input  dsst_pkg::wr_req_t     wr
);
    import dsst_pkg::*;

    entry_t               entry_mem_reg [SYNAPSES];
    entry_t               rd_data_reg;
    entry_t               byp_data_reg;
    logic [SYNAPSES-1:0]  valid_reg;
    logic                 rd_valid_reg;
    logic                 byp_hit_reg;

    // Table storage, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_mem_reg[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem_reg[rd_addr];
        end
    end

    // Forward a write that lands on the same edge as the read
    always_ff @(posedge clk)
    begin
        if (rd_en && wr.en && (wr.addr == rd_addr))
        begin
            byp_data_reg <= wr.entry;
        end
    end

    // Per-entry valid bits; an entry not yet written reads as cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                byp_hit_reg  <= wr.en && (wr.addr == rd_addr);
            end
        end
    end

    assign rd_entry = byp_hit_reg  ? byp_data_reg :
                      rd_valid_reg ? rd_data_reg  : '0;

endmodule

// ----- hdl/dsst_update.sv -----
module dsst_update (
    input  dsst_pkg::in_item_t  item,
    input  dsst_pkg::entry_t    cur,
    output dsst_pkg::entry_t    upd,
    output logic                upd_en,
    output dsst_pkg::out_item_t result
);
    import dsst_pkg::*;

    localparam int PROD_W = RESP_W + DECAY_W + 1;
    localparam int SCL_W  = PROD_W - DECAY_W;
    localparam int SUM_W  = SCL_W + 1;

    logic [RING_W-1:0]        slot;
    logic                     delivered;
    logic                     collision;
    logic signed [PROD_W-1:0] prod;
    logic signed [SCL_W-1:0]  scaled;
    logic signed [SUM_W-1:0]  addend;
    logic signed [SUM_W-1:0]  sum;
    logic signed [RESP_W-1:0] decayed;

    // Ring slot for a spike uses the stored delay; the add wraps at the ring length
    assign slot      = cur.read_pos + cur.delay[RING_W-1:0];
    assign delivered = cur.ring[cur.read_pos];
    assign collision = cur.ring[slot];

    // Decay: Q0.16 multiply, arithmetic floor, add weight if delivered, saturate
    assign prod    = $signed(cur.response) * $signed({1'b0, cur.decay});
    assign scaled  = prod[PROD_W-1:DECAY_W];
    assign addend  = delivered ? SUM_W'(cur.weight) : '0;
    assign sum     = SUM_W'(scaled) + addend;

    always_comb
    begin
        if (sum[SUM_W-1:RESP_W-1] == '0 || sum[SUM_W-1:RESP_W-1] == '1)
        begin
            decayed = sum[RESP_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            decayed = {1'b1, {(RESP_W-1){1'b0}}};
        end
        else
        begin
            decayed = {1'b0, {(RESP_W-1){1'b1}}};
        end
    end

    // Mode decode
    always_comb
    begin
        upd    = cur;
        upd_en = 1'b1;
        result.synapse_echo    = item.synapse_index;
        result.spike_delivered = 1'b0;
        result.collision_error = 1'b0;
        unique case (item.mode)
            MODE_LOAD:
            begin
                upd.ring     = '0;
                upd.read_pos = '0;
                upd.delay    = item.delay_ticks;
                upd.weight   = item.weight;
                upd.decay    = item.decay;
                upd.response = '0;
            end
            MODE_SPIKE:
            begin
                upd.ring[slot]         = 1'b1;
                result.collision_error = collision;
            end
            MODE_TICK:
            begin
                upd.ring[cur.read_pos] = 1'b0;
                upd.read_pos           = cur.read_pos + 1'b1;
                upd.response           = decayed;
                result.spike_delivered = delivered;
            end
            default:
            begin
                upd_en = 1'b0;
            end
        endcase
        result.response = upd.response;
    end

endmodule

// ----- hdl/delayed_spike_synapse_table.sv -----
// Channel  | Handshake                   | Beat
// ---------+-----------------------------+-----------------------------
// item     | item_valid / item_stall     | dsst_pkg::in_item_t item
// result   | result_valid / result_stall | dsst_pkg::out_item_t result
//
// One beat in per cycle while the result side does not stall.
// The path from the table read register through the 32x16 multiply,
// weight add and saturation to the result register sets the clock.
// Reset clears the valid bits of all 256 entries at once: no clearing pass.
// A stalled result holds the item stage, which then stalls the input.
module delayed_spike_synapse_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  dsst_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output dsst_pkg::out_item_t  result
);
    import dsst_pkg::*;

`include "delayed_spike_synapse_table_macros.svh"

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;
    logic      accept;
    logic      advance;
    entry_t    cur_entry;
    entry_t    upd_entry;
    logic      upd_en;
    out_item_t upd_result;
    wr_req_t   wr;

    // Handshake
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    // Table with read register and write forwarding
    assign wr.en    = advance && upd_en;
    assign wr.addr  = in_item_reg.synapse_index;
    assign wr.entry = upd_entry;

    dsst_entry_ram u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (item.synapse_index),
        .rd_entry (cur_entry),
        .wr       (wr)
    );

    dsst_update u_update (
        .item   (in_item_reg),
        .cur    (cur_entry),
        .upd    (upd_entry),
        .upd_en (upd_en),
        .result (upd_result)
    );

    // Stage occupancy
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_reg <= upd_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Checks
    `DSST_ASSERT_NEXT(a_item_reaches_result, advance, result_valid)
    `DSST_ASSERT_NEXT(a_echo_tracks_item, advance,
        result.synapse_echo == $past(in_item_reg.synapse_index))
    `DSST_ASSERT_NOW(a_flags_exclusive, result_valid,
        !(result.spike_delivered && result.collision_error))
    `DSST_ASSERT_NEXT(a_load_clears_response,
        advance && (in_item_reg.mode == MODE_LOAD), result.response == '0)
    `DSST_ASSERT_NOW(a_no_write_on_hold, !advance, !wr.en)

endmodule

// ----- test/tb_delayed_spike_synapse_table.sv -----
module tb_delayed_spike_synapse_table;
    import dsst_pkg::*;

    localparam int  LIMIT       = 1000000;
    localparam int  RAND_ITEMS  = 1420;
    localparam int  PUMP_PAIRS  = 270;
    localparam int  PUMP_CHUNK  = 20;
    localparam logic [IDX_W-1:0] PUMP_UP   = 8'd200;
    localparam logic [IDX_W-1:0] PUMP_DOWN = 8'd201;

    logic clk;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    in_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_item_t result;

    // Side band that travels with each beat: a hand-written expectation
    logic beat_typed = 1'b0;
    out_item_t beat_want = '0;

    delayed_spike_synapse_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Shadow copy of the synapse table
    logic [RING_LEN-1:0]        syn_ring   [SYNAPSES];
    logic [RING_W-1:0]          syn_pos    [SYNAPSES];
    logic [DELAY_W-1:0]         syn_delay  [SYNAPSES];
    logic signed [WEIGHT_W-1:0] syn_weight [SYNAPSES];
    logic [DECAY_W-1:0]         syn_decay  [SYNAPSES];
    logic signed [RESP_W-1:0]   syn_resp   [SYNAPSES];
    bit                         loaded     [SYNAPSES];

    out_item_t pending_results[$];

    int n_sent = 0;
    int n_directed = 0;
    int n_mismatch = 0;
    int n_load = 0, n_spike = 0, n_tick = 0, n_idle_mode = 0;
    int n_coll = 0, n_deliv = 0, n_sat = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit pump_active = 1'b0;

    initial
    begin
        for (int i = 0; i < SYNAPSES; i++)
        begin
            syn_ring[i]   = '0;
            syn_pos[i]    = '0;
            syn_delay[i]  = '0;
            syn_weight[i] = '0;
            syn_decay[i]  = '0;
            syn_resp[i]   = '0;
            loaded[i]     = 1'b0;
        end
    end

    // Applies one beat to the shadow table and returns the result it causes
    function automatic out_item_t synapse_step_result(in_item_t b);
        out_item_t r;
        int unsigned i;
        logic [RING_W-1:0] slot;
        longint prod;
        longint acc;
        i = b.synapse_index;
        r = '0;
        r.synapse_echo = b.synapse_index;
        case (b.mode)
            MODE_LOAD:
            begin
                syn_weight[i] = b.weight;
                syn_decay[i]  = b.decay;
                syn_delay[i]  = b.delay_ticks;
                syn_ring[i]   = '0;
                syn_pos[i]    = '0;
                syn_resp[i]   = '0;
                n_load++;
            end
            MODE_SPIKE:
            begin
                // 5-bit sum wraps at the ring length
                slot = syn_pos[i] + syn_delay[i];
                r.collision_error = syn_ring[i][slot];
                syn_ring[i][slot] = 1'b1;
                n_spike++;
                if (r.collision_error)
                    n_coll++;
            end
            MODE_TICK:
            begin
                r.spike_delivered = syn_ring[i][syn_pos[i]];
                syn_ring[i][syn_pos[i]] = 1'b0;
                syn_pos[i] = syn_pos[i] + 1'b1;
                // floor of response * decay / 2^16, then weight, then clamp
                prod = longint'(syn_resp[i]) * longint'({1'b0, syn_decay[i]});
                acc = prod >>> 16;
                if (r.spike_delivered)
                    acc = acc + longint'(syn_weight[i]);
                if (acc > 64'sd2147483647)
                begin
                    acc = 64'sd2147483647;
                    n_sat++;
                end
                else if (acc < -64'sd2147483648)
                begin
                    acc = -64'sd2147483648;
                    n_sat++;
                end
                syn_resp[i] = acc[RESP_W-1:0];
                n_tick++;
                if (r.spike_delivered)
                    n_deliv++;
            end
            default:
                n_idle_mode++;
        endcase
        r.response = syn_resp[i];
        return r;
    endfunction

    // Prediction on accepted items, comparison on accepted results
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                want = synapse_step_result(item);
                if (beat_typed)
                    want = beat_want;
                pending_results.push_back(want);
            end
            if (result_valid && !result_stall)
            begin
                got = result;
                if (pending_results.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result beat: echo %0d resp %0d deliv %0b coll %0b",
                                 got.synapse_echo, got.response, got.spike_delivered,
                                 got.collision_error);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.synapse_echo !== want.synapse_echo
                        || got.response !== want.response
                        || got.spike_delivered !== want.spike_delivered
                        || got.collision_error !== want.collision_error)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                        begin
                            $display("bad result beat: want echo %0d resp %0d deliv %0b coll %0b",
                                     want.synapse_echo, want.response, want.spike_delivered,
                                     want.collision_error);
                            $display("                  got echo %0d resp %0d deliv %0b coll %0b",
                                     got.synapse_echo, got.response, got.spike_delivered,
                                     got.collision_error);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result backpressure: styles switch every stretch, style 0 starts no new stalls
    int stall_style = 0;
    int style_left = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(30, 150);
        end
        else
            style_left--;
        if (hold_left > 0)
            hold_left--;
        else if (stall_style == 1 && $urandom_range(0, 99) < 20)
            hold_left = $urandom_range(1, 2);
        else if (stall_style == 2 && $urandom_range(0, 99) < 30)
            hold_left = $urandom_range(1, 4);
        else if (stall_style == 3 && $urandom_range(0, 99) < 8)
            hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        result_stall <= (hold_left > 0);
    end

    // Offers one beat, waits for it to be taken, then may idle a random gap
    task automatic send_beat(input in_item_t b, input logic typed, input out_item_t want);
        int gap;
        int r;
        item       <= b;
        beat_typed <= typed;
        beat_want  <= want;
        item_valid <= 1'b1;
        if (b.mode == MODE_LOAD)
            loaded[b.synapse_index] = 1'b1;
        do @(posedge clk); while (item_stall);
        n_sent++;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            gap = 0;
        else if (r < 88)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 40);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx);
        in_item_t b;
        b.mode          = m;
        b.synapse_index = idx;
        b.weight        = WEIGHT_W'($urandom);
        b.decay         = DECAY_W'($urandom);
        b.delay_ticks   = DELAY_W'($urandom);
        send_beat(b, 1'b0, '0);
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] w,
                             input logic [DECAY_W-1:0] d, input logic [DELAY_W-1:0] dl);
        in_item_t b;
        b.mode          = MODE_LOAD;
        b.synapse_index = idx;
        b.weight        = w;
        b.decay         = d;
        b.delay_ticks   = dl;
        send_beat(b, 1'b0, '0);
    endtask

    // Load with a bias toward the field extremes
    task automatic send_load_rand(input logic [IDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        logic [DECAY_W-1:0] d;
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            w = 24'h7FFFFF;
        else if (r < 30)
            w = 24'h800000;
        else if (r < 40)
            w = '0;
        else
            w = WEIGHT_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)
            d = '0;
        else if (r < 30)
            d = 16'hFFFF;
        else if (r < 50)
            d = DECAY_W'($urandom_range(65000, 65535));
        else
            d = DECAY_W'($urandom);
        send_load(idx, w, d, DELAY_W'($urandom_range(0, 31)));
    endtask

    // Mostly a small hot set so rings wrap and collide; never a busy pump synapse
    function automatic logic [IDX_W-1:0] pick_idx();
        logic [IDX_W-1:0] i;
        do
        begin
            if ($urandom_range(0, 9) < 7)
                i = IDX_W'($urandom_range(0, 11) * 21);
            else
                i = IDX_W'($urandom_range(0, 255));
        end
        while (pump_active && (i == PUMP_UP || i == PUMP_DOWN));
        return i;
    endfunction

    // Spike then tick on one synapse, so nearly every tick adds the weight
    task automatic pump_chunk(input logic [IDX_W-1:0] idx, input int pairs);
        repeat (pairs)
        begin
            send_op(MODE_SPIKE, idx);
            if ($urandom_range(0, 24) == 0)
                send_op(MODE_SPIKE, idx);
            send_op(MODE_TICK, idx);
            if ($urandom_range(0, 14) == 0)
                send_op(MODE_NONE, IDX_W'($urandom));
        end
    endtask

    // One edge first so the beat taken at the last edge is already queued
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Directed rows
    typedef struct packed {
        in_item_t  beat;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    task automatic add_row(input logic [MODE_W-1:0] m, input int idx, input int w,
                           input int d, input int dl, input logic typed, input int resp,
                           input logic deliv, input logic coll);
        dir_row_t row;
        row.beat.mode              = m;
        row.beat.synapse_index     = IDX_W'(idx);
        row.beat.weight            = WEIGHT_W'(w);
        row.beat.decay             = DECAY_W'(d);
        row.beat.delay_ticks       = DELAY_W'(dl);
        row.typed                  = typed;
        row.want.synapse_echo      = IDX_W'(idx);
        row.want.response          = resp;
        row.want.spike_delivered   = deliv;
        row.want.collision_error   = coll;
        dir_rows.push_back(row);
    endtask

    initial
    begin : stimulus
        int pump_left [2];
        int k;
        int chunk;
        int len;
        int r;
        bit paused;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] other;

        //      mode        idx  weight     decay  dly typed resp     dv co
        add_row(MODE_NONE,    0,        0,     0,  0, 1,        0, 0, 0);
        add_row(MODE_NONE,  255, -1,   65535, 31, 1,        0, 0, 0);
        add_row(MODE_LOAD,    0,  8388607, 65535,  1, 1,        0, 0, 0);
        add_row(MODE_LOAD,  255, -8388608,     0, 31, 1,        0, 0, 0);
        add_row(MODE_SPIKE,   0,        0,     0,  0, 1,        0, 0, 0);
        // same slot again: collision, bit stays set
        add_row(MODE_SPIKE,   0, -1,   65535, 31, 1,        0, 0, 1);
        add_row(MODE_TICK,    0,        0,     0,  0, 1,        0, 0, 0);
        add_row(MODE_TICK,    0,        0,     0,  0, 1,  8388607, 1, 0);
        add_row(MODE_TICK,    0,        0,     0,  0, 0,        0, 0, 0);
        add_row(MODE_SPIKE, 255,        0,     0,  0, 1,        0, 0, 0);
        // zero delay lands on the slot the next tick reads
        add_row(MODE_LOAD,    7, -8388608, 65535,  0, 1,        0, 0, 0);
        add_row(MODE_SPIKE,   7,        0,     0,  0, 1,        0, 0, 0);
        add_row(MODE_TICK,    7,        0,     0,  0, 1, -8388608, 1, 0);
        add_row(MODE_TICK,    7,        0,     0,  0, 0,        0, 0, 0);
        add_row(MODE_NONE,    7,  8388607, 65535, 31, 0,        0, 0, 0);
        add_row(MODE_LOAD,  128,        0, 32768, 16, 1,        0, 0, 0);
        add_row(MODE_SPIKE, 128,        0,     0,  0, 1,        0, 0, 0);
        add_row(MODE_TICK,  128,        0,     0,  0, 1,        0, 0, 0);
        // reload clears ring, position and response
        add_row(MODE_LOAD,    0,        1,     1,  5, 1,        0, 0, 0);
        add_row(MODE_TICK,    0,        0,     0,  0, 1,        0, 0, 0);
        add_row(MODE_TICK,  255,        0,     0,  0, 1,        0, 0, 0);
        add_row(MODE_NONE,    0,        0,     0,  0, 1,        0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1'b0;
        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        n_directed = n_sent;
        hold_until_drained();

        // Random part: saturation pumps interleaved with load/spike/tick runs
        pump_left[0] = PUMP_PAIRS;
        pump_left[1] = PUMP_PAIRS;
        pump_active = 1'b1;
        paused = 1'b0;
        while (n_sent - n_directed < RAND_ITEMS || pump_left[0] > 0 || pump_left[1] > 0)
        begin
            if (!paused && n_sent - n_directed > RAND_ITEMS / 2)
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            calm = ($urandom_range(0, 4) == 0);
            if ((pump_left[0] > 0 || pump_left[1] > 0) && $urandom_range(0, 3) != 0)
            begin
                k = (pump_left[0] > 0) ? 0 : 1;
                idx = (k == 0) ? PUMP_UP : PUMP_DOWN;
                if (pump_left[k] == PUMP_PAIRS)
                    send_load(idx, (k == 0) ? 24'h7FFFFF : 24'h800000, 16'hFFFF,
                              DELAY_W'($urandom_range(0, 2)));
                chunk = (pump_left[k] < PUMP_CHUNK) ? pump_left[k] : PUMP_CHUNK;
                pump_chunk(idx, chunk);
                pump_left[k] -= chunk;
                if (pump_left[0] == 0 && pump_left[1] == 0)
                    pump_active = 1'b0;
            end
            else
            begin
                idx = pick_idx();
                if (!loaded[idx] || $urandom_range(0, 5) == 0)
                    send_load_rand(idx);
                len = $urandom_range(4, 30);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        send_op(MODE_SPIKE, idx);
                    else if (r < 85)
                        send_op(MODE_TICK, idx);
                    else if (r < 92)
                        send_op(MODE_NONE, IDX_W'($urandom));
                    else
                    begin
                        other = pick_idx();
                        if (!loaded[other])
                            send_load_rand(other);
                        else if ($urandom_range(0, 1) == 0)
                            send_op(MODE_SPIKE, other);
                        else
                            send_op(MODE_TICK, other);
                    end
                end
            end
        end

        // Drain, then let the pipeline settle
        hold_until_drained();
        repeat (8) @(posedge clk);

        $display("%0d beats: %0d loads, %0d spikes (%0d collisions), %0d ticks, %0d idle-mode",
                 n_sent, n_load, n_spike, n_coll, n_tick, n_idle_mode);
        $display("%0d spikes delivered, %0d clamped responses, %0d mismatches",
                 n_deliv, n_sat, n_mismatch);
        if (n_mismatch == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
